// ===== rtl/relative_path_sanitizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the relative path sanitizer checker
// Each macro expands to one labeled concurrent assertion clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_PATH_SANITIZER_ASSERT_SVH
`define RELATIVE_PATH_SANITIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("relative_path_sanitizer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("relative_path_sanitizer: assertion failed");

// Next-cycle implication that also holds across reset.
`define RPS_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("relative_path_sanitizer: reset assertion failed");

`endif

// ===== rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// Widths, character codes and helper functions of the relative path sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

    // Field and register widths.
    localparam int CharW  = 8;
    localparam int SizeW  = 9;
    localparam int CountW = 9;
    localparam int SegW   = 2;

    // Largest buffer the block ever honors.
    localparam int MaxPathBytes = 256;

    // Reset value of the buffer size register.
    localparam logic [SizeW-1:0] SizeReset = SizeW'(256);

    // Saturation limits.
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [SegW-1:0]   SegMax   = '1;

    // Character codes.
    localparam logic [CharW-1:0] ChrPrintLo = 8'd32;
    localparam logic [CharW-1:0] ChrPrintHi = 8'd126;
    localparam logic [CharW-1:0] ChrSlash   = 8'h2F;
    localparam logic [CharW-1:0] ChrBslash  = 8'h5C;
    localparam logic [CharW-1:0] ChrColon   = 8'h3A;
    localparam logic [CharW-1:0] ChrDot     = 8'h2E;

    // Bit positions in the result tuser.
    localparam int UserOk       = 0;
    localparam int UserAccepted = 1;
    localparam int OutUserW     = 2;

    // True when the segment that just ended is empty, "." or "..".
    function automatic logic bad_segment(input logic [SegW-1:0] seg_len,
                                         input logic            prev_dot,
                                         input logic            prev2_dot);
        logic bad;
        bad = (seg_len == SegW'(0))
            || ((seg_len == SegW'(1)) && prev_dot)
            || ((seg_len == SegW'(2)) && prev_dot && prev2_dot);
        return bad;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/relative_path_sanitizer.sv =====
// ----------------------------------------------------------------------------
// relative_path_sanitizer
// Streaming check and normalization of archive paths, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one raw path byte per beat in s_tdata, s_tlast
//   marks the final byte of a path and s_tuser flags an empty path (that beat
//   carries no character and ends the path). Each input beat yields exactly
//   one result beat: the byte with either slash kind turned into '/', a
//   running "no check failed" flag, tlast on the path's final beat, and the
//   verdict on that final beat.
//   The buffer size register is written through cfg_valid/cfg_data; the user
//   must write it only while the block is idle, which the block itself does
//   not enforce; cfg_ready is always high. An accepted input beat passes
//   through the input register, then the result register. One beat is
//   accepted every cycle while the receiver does not stall; the check logic
//   between the two stages is combinational. When the receiver stalls, the
//   result register holds its beat and the input register can still take one
//   more beat before s_tready drops. Synchronous reset clears both stages and
//   the per-path state and sets the buffer size to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module relative_path_sanitizer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration: buffer size
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rps_pkg::SizeW-1:0]    cfg_data,
    // Input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rps_pkg::CharW-1:0]    s_tdata,   // [7:0] path_char
    input  wire logic                         s_tlast,   // last_char
    input  wire logic                         s_tuser,   // empty_path
    // Result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rps_pkg::CharW-1:0]         m_tdata,   // [7:0] out_char
    output logic                              m_tlast,   // path_done
    output logic [rps_pkg::OutUserW-1:0]      m_tuser    // [0] ok_so_far, [1] path_accepted
);
    import rps_pkg::*;

    // Configuration register
    logic [SizeW-1:0]  size_reg;

    // Input stage
    logic              in_valid_reg;
    logic [CharW-1:0]  in_char_reg;
    logic              in_last_reg;
    logic              in_empty_reg;

    // Per-path state
    logic [CountW-1:0] count_reg,     count_next;
    logic [SegW-1:0]   seg_reg,       seg_next;
    logic              prev_dot_reg,  prev_dot_next;
    logic              prev2_dot_reg, prev2_dot_next;
    logic              failed_reg,    failed_next;

    // Result stage
    logic              out_valid_reg;
    logic [CharW-1:0]  out_char_reg,  out_char_next;
    logic              out_ok_reg,    out_ok_next;
    logic              out_done_reg,  out_done_next;
    logic              out_acc_reg,   out_acc_next;

    // Handshake
    logic              out_adv;
    logic              in_adv;
    logic              s_beat;

    // Check logic
    logic [SizeW-1:0]  size_eff;
    logic              is_slash;
    logic              fail;

    assign cfg_ready = 1'b1;
    assign out_adv   = !out_valid_reg || m_tready;
    assign in_adv    = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign s_beat    = s_tvalid && s_tready;

    assign m_tvalid              = out_valid_reg;
    assign m_tdata               = out_char_reg;
    assign m_tlast               = out_done_reg;
    assign m_tuser[UserOk]       = out_ok_reg;
    assign m_tuser[UserAccepted] = out_acc_reg;

    // Clamp the buffer size to the largest supported path.
    always_comb begin
        if (int'(size_reg) > MaxPathBytes) begin
            size_eff = SizeW'(MaxPathBytes);
        end else begin
            size_eff = size_reg;
        end
    end

    // Per-character checks and next path state.
    always_comb begin
        is_slash = (in_char_reg == ChrSlash) || (in_char_reg == ChrBslash);
        fail     = failed_reg;

        if ((in_char_reg < ChrPrintLo) || (in_char_reg > ChrPrintHi)) begin
            fail = 1'b1;
        end
        if ((count_reg == CountW'(0)) && is_slash) begin
            fail = 1'b1;
        end
        if ((count_reg == CountW'(1)) && (in_char_reg == ChrColon)) begin
            fail = 1'b1;
        end
        if (is_slash && bad_segment(seg_reg, prev_dot_reg, prev2_dot_reg)) begin
            fail = 1'b1;
        end
        if (({1'b0, count_reg} + (CountW+1)'(1)) >= {1'b0, size_eff}) begin
            fail = 1'b1;
        end

        if (is_slash) begin
            seg_next = '0;
        end else if (seg_reg != SegMax) begin
            seg_next = seg_reg + SegW'(1);
        end else begin
            seg_next = seg_reg;
        end
        prev2_dot_next = prev_dot_reg;
        prev_dot_next  = (in_char_reg == ChrDot);
        count_next     = (count_reg != CountMax) ? count_reg + CountW'(1) : count_reg;

        // The final segment must also be a real name.
        if (in_last_reg && bad_segment(seg_next, prev_dot_next, prev2_dot_next)) begin
            fail = 1'b1;
        end
        failed_next = fail;

        out_char_next = is_slash ? ChrSlash : in_char_reg;
        out_ok_next   = !fail;
        out_done_next = in_last_reg;
        out_acc_next  = in_last_reg && !fail;

        // An empty path ends and rejects whatever was streamed so far.
        if (in_empty_reg) begin
            out_char_next = '0;
            out_ok_next   = 1'b0;
            out_done_next = 1'b1;
            out_acc_next  = 1'b0;
        end

        // Any path end clears the running state for the next path.
        if (in_empty_reg || in_last_reg) begin
            count_next     = '0;
            seg_next       = '0;
            prev_dot_next  = 1'b0;
            prev2_dot_next = 1'b0;
            failed_next    = 1'b0;
        end
    end

    // Configuration, pipeline valids and path state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= SizeReset;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            seg_reg       <= '0;
            prev_dot_reg  <= 1'b0;
            prev2_dot_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
            if (s_beat) begin
                in_valid_reg <= 1'b1;
            end else if (in_adv) begin
                in_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_adv) begin
                count_reg     <= count_next;
                seg_reg       <= seg_next;
                prev_dot_reg  <= prev_dot_next;
                prev2_dot_reg <= prev2_dot_next;
                failed_reg    <= failed_next;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_char_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        if (in_adv) begin
            out_char_reg <= out_char_next;
            out_ok_reg   <= out_ok_next;
            out_done_reg <= out_done_next;
            out_acc_reg  <= out_acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rps_checker.sv =====
// ----------------------------------------------------------------------------
// rps_checker
// Port-level assertions for the relative path sanitizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relative_path_sanitizer_assert.svh"

module rps_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rps_pkg::CharW-1:0]       m_tdata,
    input wire logic                            m_tlast,
    input wire logic [rps_pkg::OutUserW-1:0]    m_tuser
);
    import rps_pkg::*;

    // A verdict of "accepted" only appears on the final beat of a path.
    `RPS_ASSERT_NOW(a_accept_on_last, m_tvalid && m_tuser[UserAccepted], m_tlast)

    // An accepted path never reports a failed check on its final beat.
    `RPS_ASSERT_NOW(a_accept_is_ok, m_tvalid && m_tuser[UserAccepted], m_tuser[UserOk])

    // A stalled result beat holds until it is taken.
    `RPS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // Reset empties the result stage.
    `RPS_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid)

endmodule

bind relative_path_sanitizer rps_checker u_rps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/relative_path_sanitizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative path sanitizer testbench
// Streams directed and random archive paths through the block, one character
// per beat, and checks every result beat against a cycle-free model of the
// path rules. The run steps through several buffer sizes and idle patterns.
// ----------------------------------------------------------------------------

module relative_path_sanitizer_tb;
    import rps_pkg::*;

    // Fields of one result beat.
    typedef struct packed {
        logic [CharW-1:0] out_char;
        logic             ok_so_far;
        logic             path_done;
        logic             path_accepted;
    } path_verdict_t;

    // Model of the path rules plus the queue of result beats still due.
    class path_check_model;
        logic [SizeW-1:0]  buffer_size;
        logic [CountW-1:0] char_count;
        logic [SegW-1:0]   seg_len;
        logic              prev_dot;
        logic              prev2_dot;
        logic              path_failed;
        path_verdict_t     verdicts_due[$];
        int                mismatches;

        function new();
            buffer_size = SizeReset;
            mismatches  = 0;
            clear_path();
        endfunction

        function void clear_path();
            char_count  = '0;
            seg_len     = '0;
            prev_dot    = 1'b0;
            prev2_dot   = 1'b0;
            path_failed = 1'b0;
        endfunction

        // The segment that just ended is empty, "." or "..".
        function logic segment_is_bad();
            return (seg_len == 2'd0) || (seg_len == 2'd1 && prev_dot)
                || (seg_len == 2'd2 && prev_dot && prev2_dot);
        endfunction

        function void write_size(logic [SizeW-1:0] size);
            buffer_size = size;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Works out the result beat caused by one accepted input beat.
        function void accept_char(logic [CharW-1:0] ch, logic last, logic empty);
            path_verdict_t v;
            logic          slash;
            logic          fail;
            int            limit;
            limit = (buffer_size > MaxPathBytes) ? MaxPathBytes : int'(buffer_size);
            if (empty) begin
                v.out_char      = '0;
                v.ok_so_far     = 1'b0;
                v.path_done     = 1'b1;
                v.path_accepted = 1'b0;
                verdicts_due.push_back(v);
                clear_path();
                return;
            end
            slash = (ch == ChrSlash) || (ch == ChrBslash);
            fail  = path_failed;
            if (ch < ChrPrintLo || ch > ChrPrintHi) fail = 1'b1;
            if (char_count == 0 && slash) fail = 1'b1;
            if (char_count == 1 && ch == ChrColon) fail = 1'b1;
            if (slash && segment_is_bad()) fail = 1'b1;
            if (int'(char_count) + 1 >= limit) fail = 1'b1;

            // Advance the running segment and count state.
            if (slash) begin
                seg_len = '0;
            end else if (seg_len != SegMax) begin
                seg_len = seg_len + 1'b1;
            end
            prev2_dot = prev_dot;
            prev_dot  = (ch == ChrDot);
            if (char_count != CountMax) char_count = char_count + 1'b1;

            v.out_char      = slash ? ChrSlash : ch;
            v.path_done     = last;
            v.path_accepted = 1'b0;
            if (last) begin
                if (segment_is_bad()) fail = 1'b1;
                v.path_accepted = !fail;
            end
            path_failed = fail;
            v.ok_so_far = !fail;
            verdicts_due.push_back(v);
            if (last) clear_path();
        endfunction

        function void compare_field(string field, logic [CharW-1:0] want,
                                    logic [CharW-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %02h, got %02h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Compares one result beat with the oldest one still due.
        function void compare_beat(path_verdict_t got);
            path_verdict_t want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("ok_so_far", 8'(want.ok_so_far), 8'(got.ok_so_far));
            compare_field("path_done", 8'(want.path_done), 8'(got.path_done));
            compare_field("path_accepted", 8'(want.path_accepted), 8'(got.path_accepted));
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SizeW-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [CharW-1:0]    s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [CharW-1:0]    m_tdata;
    logic                m_tlast;
    logic [OutUserW-1:0] m_tuser;

    path_check_model path_model = new();

    int sender_gap_pct     = 20;
    int receiver_stall_pct = 76;
    int chars_accepted     = 0;
    int hold_requests      = 0;
    int holds_served       = 0;
    int hold_left          = 0;

    logic [SizeW-1:0] buffer_sizes [10] = '{9'd2, 9'd0, 9'd1, 9'd511, 9'd17,
                                            9'd300, 9'd5, 9'd3, 9'd64, 9'd256};

    relative_path_sanitizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] path_char
        .s_tlast   (s_tlast),    // last_char
        .s_tuser   (s_tuser),    // empty_path
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] out_char
        .m_tlast   (m_tlast),    // path_done
        .m_tuser   (m_tuser)     // [0] ok_so_far, [1] path_accepted
    );

    always #5 aclk = ~aclk;

    // Monitors: configuration writes, accepted input beats, result beats.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) path_model.write_size(cfg_data);
        if (aresetn && s_tvalid && s_tready) path_model.accept_char(s_tdata, s_tlast, s_tuser);
        if (aresetn && m_tvalid && m_tready) begin
            path_model.compare_beat('{out_char: m_tdata, ok_so_far: m_tuser[UserOk],
                                      path_done: m_tlast,
                                      path_accepted: m_tuser[UserAccepted]});
        end
    end

    // Receiver: random stalls, or a long hold-off when one has been requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_tready     <= 1'b0;
            hold_left    <= 90;
            holds_served <= holds_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offers one beat after a random gap and waits until it is taken.
    task automatic send_beat(input logic [CharW-1:0] ch, input logic last,
                             input logic empty);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        s_tuser  <= empty;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_accepted++;
    endtask

    // Sends a path; a cut path is ended by an empty-path beat instead of tlast.
    task automatic send_path(input logic [CharW-1:0] chars[$], input logic cut);
        foreach (chars[i]) send_beat(chars[i], (i == chars.size() - 1) && !cut, 1'b0);
        if (cut) send_beat(CharW'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic send_text(input string text);
        logic [CharW-1:0] chars[$];
        for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
        send_path(chars, 1'b0);
    endtask

    // Builds a mostly well-formed path of the given length, slashes of both
    // kinds, with an occasional ".", ".." or "..." segment.
    function automatic void fill_clean_path(ref logic [CharW-1:0] chars[$], input int len);
        int               seg_kind;
        logic [CharW-1:0] c;
        chars.delete();
        while (chars.size() < len) begin
            if (chars.size() != 0) chars.push_back($urandom_range(1) ? ChrSlash : ChrBslash);
            seg_kind = $urandom_range(19);
            if (seg_kind < 3) begin
                repeat (seg_kind + 1) chars.push_back(ChrDot);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    do c = CharW'($urandom_range(ChrPrintLo, ChrPrintHi));
                    while (c == ChrSlash || c == ChrBslash);
                    chars.push_back(c);
                end
            end
        end
        while (chars.size() > len) void'(chars.pop_back());
    endfunction

    task automatic send_random_path();
        logic [CharW-1:0] chars[$];
        int               kind;
        int               len;
        int               pick;
        kind = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 10);
        if (kind < 4) begin
            send_beat(CharW'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else if (kind < 84) begin
            fill_clean_path(chars, len);
            send_path(chars, 1'b0);
        end else begin
            // Noise: raw bytes with plenty of slashes, dots and colons.
            repeat (len) begin
                pick = $urandom_range(9);
                case (pick)
                    0:       chars.push_back(ChrSlash);
                    1:       chars.push_back(ChrBslash);
                    2:       chars.push_back(ChrDot);
                    3:       chars.push_back(ChrColon);
                    4:       chars.push_back(CharW'($urandom_range(255)));
                    default: chars.push_back(CharW'($urandom_range(ChrPrintLo, ChrPrintHi)));
                endcase
            end
            send_path(chars, $urandom_range(2) == 0);
        end
    endtask

    // Stops offering and waits until every expected result beat has come.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (path_model.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_buffer_size(input logic [SizeW-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One buffer size: a path near the length limit where that is cheap, then
    // random paths.
    task automatic run_phase(input logic [SizeW-1:0] size, input int n_chars,
                             input logic long_hold);
        logic [CharW-1:0] chars[$];
        int               eff;
        int               start;
        wait_for_results();
        write_buffer_size(size);
        eff = (size > MaxPathBytes) ? MaxPathBytes : int'(size);
        if (eff <= 64 || size > MaxPathBytes) begin
            fill_clean_path(chars, ((eff > 2) ? eff - 2 : 1) + $urandom_range(2));
            send_path(chars, 1'b0);
        end
        if (long_hold) hold_requests <= hold_requests + 1;
        start = chars_accepted;
        while (chars_accepted - start < n_chars) send_random_path();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed paths at the reset buffer size.
        send_text("a\\b");      // backslash normalized, path accepted
        send_text("/x");        // leading slash
        send_text("c:");        // drive colon as second character
        send_text(".");         // lone dot segment
        send_text("..\\a");     // dot-dot segment
        send_text("a/");        // trailing empty segment
        send_text("a:b");       // colon as second character again
        send_text(" ~");        // printable range edges
        send_beat(8'hFF, 1'b1, 1'b1);   // empty path, character and tlast ignored
        send_beat("a", 1'b0, 1'b0);     // partly streamed path cut by an empty path
        send_beat("b", 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);   // zero byte
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b0);

        // Random phases over several buffer sizes and idle patterns.
        foreach (buffer_sizes[i]) begin
            if (i == 3) begin
                sender_gap_pct     = 76;
                receiver_stall_pct = 20;
            end
            if (i == 6) begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            run_phase(buffer_sizes[i], 30, i == 6);
        end

        wait_for_results();
        if (path_model.mismatches == 0 && path_model.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
